/* design/afs_pkg.sv */
// shared types and constants for the animation frame sequencer
`default_nettype none
package afs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 11;
    localparam int REPEAT_W   = 16;
    localparam int STRIDE_W   = 14;
    localparam int DIM_W      = 12;
    localparam int MODE_W     = 2;
    localparam int INDEX_W    = 12;
    localparam int FRAME_W    = 10;
    localparam int OFFSET_W   = 35;
    localparam int PASS_W     = 16;
    localparam int BYTES_W    = 27;

    localparam logic [MODE_W-1:0] MODE_NEXT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PREV = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SET  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_TOTAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_FIRST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_LAST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_REPEATS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_PLANE  = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_SUM  = 4'b0100,
        ST_PROD = 4'b1000
    } t_state;

    typedef struct packed {
        logic step;
        logic mul;
        logic sum;
        logic load;
    } t_cmd;

endpackage
`default_nettype wire

/* design/afs_ctrl.sv */
// controller: sequences the step, the size multiplies and the output load
`default_nettype none
module afs_ctrl (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output afs_pkg::t_cmd o_cmd
);
    import afs_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.step = i_in_valid && o_in_ready;
        o_cmd.mul  = (r_state == ST_MUL);
        o_cmd.sum  = (r_state == ST_SUM);
        o_cmd.load = (r_state == ST_PROD) && out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_MUL;
            ST_MUL:  n_state = ST_SUM;
            ST_SUM:  n_state = ST_PROD;
            ST_PROD: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

/* design/afs_datapath.sv */
// datapath: config registers, frame and pass counters, frame size and offset
`default_nettype none
module afs_datapath #(
    parameter int MAX_FRAMES = 1024
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [afs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [afs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  afs_pkg::t_cmd                 i_cmd,
    input  wire [afs_pkg::MODE_W-1:0]     i_mode,
    input  wire [afs_pkg::INDEX_W-1:0]    i_frame_index,
    output logic [afs_pkg::FRAME_W-1:0]   o_frame_now,
    output logic [afs_pkg::OFFSET_W-1:0]  o_frame_offset
);
    import afs_pkg::*;

    // the effective count is at most 2047; the counter stays below it unless the count shrinks
    localparam int CNT_MAX = (MAX_FRAMES < 2047) ? MAX_FRAMES : 2047;
    localparam int FW      = $clog2(CNT_MAX);
    localparam int PW      = BYTES_W + FW;

    logic [COUNT_W-1:0]  r_frames_total, r_loop_first, r_loop_last;
    logic [REPEAT_W-1:0] r_loop_repeats;
    logic [STRIDE_W-1:0] r_row_stride;
    logic [DIM_W-1:0]    r_image_width, r_image_height;
    logic                r_alpha_plane;

    logic [FW-1:0]       r_frame, n_frame;
    logic [PASS_W-1:0]   r_pass, n_pass;

    logic [STRIDE_W+DIM_W-1:0] r_main_bytes;
    logic [2*DIM_W-1:0]        r_alpha_bytes;
    logic [BYTES_W-1:0]        r_bytes;
    logic [PW-1:0]             prod;
    logic [FRAME_W-1:0]        r_frame_now;
    logic [OFFSET_W-1:0]       r_frame_offset;

    logic [COUNT_W-1:0] n_eff, lend, lstart;
    logic [COUNT_W:0]   f_next;
    logic               loop_hit;
    logic [INDEX_W-1:0] mag;

    // effective frame count and clamped loop bounds
    always_comb begin
        if (r_frames_total == '0) begin
            n_eff = COUNT_W'(1);
        end else if (32'(r_frames_total) > 32'(MAX_FRAMES)) begin
            n_eff = COUNT_W'(CNT_MAX);
        end else begin
            n_eff = r_frames_total;
        end
        lend   = (r_loop_last < n_eff) ? r_loop_last : n_eff;
        lstart = (r_loop_first < n_eff) ? r_loop_first : n_eff;
    end

    always_comb begin
        n_frame  = r_frame;
        n_pass   = r_pass;
        f_next   = (COUNT_W+1)'(r_frame) + (COUNT_W+1)'(1);
        loop_hit = (r_loop_repeats != '0) && (f_next == {1'b0, lend}) &&
                   ((signed'({1'b0, r_pass}) <
                     signed'({r_loop_repeats[REPEAT_W-1], r_loop_repeats}))
                    || r_loop_repeats[REPEAT_W-1]);
        mag      = i_frame_index[INDEX_W-1] ? (INDEX_W'(0) - i_frame_index) : i_frame_index;
        if (i_cmd.step) begin
            case (i_mode)
                MODE_NEXT: begin
                    if (loop_hit) begin
                        f_next = {1'b0, lstart};
                        if (r_pass != '1) n_pass = r_pass + PASS_W'(1);
                    end
                    if (f_next >= {1'b0, n_eff}) begin
                        n_pass  = PASS_W'(1);
                        n_frame = '0;
                    end else begin
                        n_frame = FW'(f_next);
                    end
                end
                MODE_PREV: begin
                    if (r_frame == '0) n_frame = FW'(n_eff - COUNT_W'(1));
                    else               n_frame = r_frame - FW'(1);
                end
                MODE_SET: begin
                    if (mag < {1'b0, n_eff}) begin
                        if (i_frame_index[INDEX_W-1]) begin
                            n_frame = FW'({1'b0, n_eff} - mag);
                        end else begin
                            n_frame = FW'(mag);
                        end
                    end
                end
                default: n_frame = r_frame;
            endcase
        end
        // loop register writes restart the pass count
        if (i_cfg_we && (i_cfg_idx == REG_LOOP_FIRST || i_cfg_idx == REG_LOOP_LAST ||
                         i_cfg_idx == REG_LOOP_REPEATS)) begin
            n_pass = PASS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_total <= COUNT_W'(1);
            r_loop_first   <= '0;
            r_loop_last    <= COUNT_W'(1);
            r_loop_repeats <= '0;
            r_row_stride   <= STRIDE_W'(1);
            r_image_width  <= DIM_W'(1);
            r_image_height <= DIM_W'(1);
            r_alpha_plane  <= 1'b0;
            r_frame        <= '0;
            r_pass         <= PASS_W'(1);
        end else begin
            r_frame <= n_frame;
            r_pass  <= n_pass;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAMES_TOTAL: r_frames_total <= i_cfg_data[COUNT_W-1:0];
                    REG_LOOP_FIRST:   r_loop_first   <= i_cfg_data[COUNT_W-1:0];
                    REG_LOOP_LAST:    r_loop_last    <= i_cfg_data[COUNT_W-1:0];
                    REG_LOOP_REPEATS: r_loop_repeats <= i_cfg_data[REPEAT_W-1:0];
                    REG_ROW_STRIDE:   r_row_stride   <= i_cfg_data[STRIDE_W-1:0];
                    REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[DIM_W-1:0];
                    REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[DIM_W-1:0];
                    REG_ALPHA_PLANE:  r_alpha_plane  <= i_cfg_data[0];
                    default:          r_alpha_plane  <= r_alpha_plane;
                endcase
            end
        end
    end

    assign prod = PW'(r_bytes) * PW'(r_frame);

    // frame size in two steps, then one multiply by the frame number
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_main_bytes  <= (STRIDE_W+DIM_W)'(r_row_stride) *
                             (STRIDE_W+DIM_W)'(r_image_height);
            r_alpha_bytes <= (2*DIM_W)'(r_image_width) * (2*DIM_W)'(r_image_height);
        end
        if (i_cmd.sum) begin
            r_bytes <= BYTES_W'(r_main_bytes) +
                       (r_alpha_plane ? BYTES_W'(r_alpha_bytes) : BYTES_W'(0));
        end
        if (i_cmd.load) begin
            r_frame_now    <= FRAME_W'(r_frame);
            r_frame_offset <= OFFSET_W'(prod);
        end
    end

    assign o_frame_now    = r_frame_now;
    assign o_frame_offset = r_frame_offset;

endmodule
`default_nettype wire

/* design/animation_frame_sequencer_core.sv */
// Animation frame sequencer: steps the current frame and reports its byte offset.
// Input channel (i_in_valid / o_in_ready) carries one command beat: i_mode selects
// next, previous or set, and i_frame_index is the signed target for set.
// Output channel (o_out_valid / i_out_ready) returns one beat per command with the
// new frame number and its offset, frame size times frame number.
// The frame counter updates on the accepting edge; the frame size is computed in
// a multiply state and then an add state, and the offset multiply lands in the
// output register from the product state once that register is free.
// One command is in flight at a time; a new one is taken only after the last has
// left the three-step multiply sequence.
// If the receiver stalls, the result waits in the output register and the next
// command may still be accepted; that command then waits before its offset
// multiply until the register is free.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect on the edge
// and belong in idle periods. Reset loads the register defaults, frame 0 and
// pass count 1, and empties the output.
`default_nettype none
module animation_frame_sequencer_core #(
    parameter int MAX_FRAMES = 1024
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [afs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [afs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire [afs_pkg::MODE_W-1:0]     i_mode,
    input  wire [afs_pkg::INDEX_W-1:0]    i_frame_index,
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic [afs_pkg::FRAME_W-1:0]   o_frame_now,
    output logic [afs_pkg::OFFSET_W-1:0]  o_frame_offset
);
    import afs_pkg::*;

    t_cmd cmd;

    afs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    afs_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .i_mode         (i_mode),
        .i_frame_index  (i_frame_index),
        .o_frame_now    (o_frame_now),
        .o_frame_offset (o_frame_offset)
    );

endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for the animation frame sequencer core
module tb;
    import afs_pkg::*;

    localparam int MAX_FRAMES     = 1024;
    localparam int STALL_PCT      = 27;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame;
        logic [OFFSET_W-1:0] offset;
    } t_frame_report;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  cmd_valid = 1'b0;
    logic [MODE_W-1:0]     cmd_mode  = MODE_NEXT;
    logic [INDEX_W-1:0]    cmd_index = '0;
    logic                  out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [FRAME_W-1:0]    o_frame_now;
    logic [OFFSET_W-1:0]   o_frame_offset;

    // sequencer model: registers and state as after reset
    logic [COUNT_W-1:0]  reg_frames_total = 11'd1;
    logic [COUNT_W-1:0]  reg_loop_first   = 11'd0;
    logic [COUNT_W-1:0]  reg_loop_last    = 11'd1;
    int                  reg_loop_repeats = 0;
    logic [STRIDE_W-1:0] reg_row_stride   = 14'd1;
    logic [DIM_W-1:0]    reg_image_width  = 12'd1;
    logic [DIM_W-1:0]    reg_image_height = 12'd1;
    logic                reg_alpha_plane  = 1'b0;
    logic [FRAME_W-1:0]  cur_frame        = '0;
    logic [PASS_W-1:0]   pass_count       = 16'd1;

    t_frame_report pending_reports[$];

    bit calm = 1'b0;
    int errors = 0;
    int commands_sent = 0;
    int reports_seen = 0;
    int settings_loaded = 0;
    int quiet_cycles = 0;

    animation_frame_sequencer_core #(.MAX_FRAMES(MAX_FRAMES)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (cmd_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (cmd_mode),
        .i_frame_index  (cmd_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_frame_now    (o_frame_now),
        .o_frame_offset (o_frame_offset)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        out_ready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
    end

    function automatic int unsigned active_frames();
        int unsigned n;
        n = reg_frames_total;
        if (n == 0) n = 1;
        if (n > MAX_FRAMES) n = MAX_FRAMES;
        return n;
    endfunction

    task automatic predict_step(input logic [MODE_W-1:0] op, input logic [INDEX_W-1:0] target);
        int unsigned n;
        int unsigned nxt;
        int unsigned loop_end;
        int unsigned loop_start;
        int unsigned mag;
        int idx;
        logic [63:0] size_bytes;
        t_frame_report rpt;
        n = active_frames();
        idx = $signed(target);
        case (op)
            MODE_NEXT: begin
                nxt = cur_frame + 1;
                loop_end = (reg_loop_last < n) ? reg_loop_last : n;
                loop_start = (reg_loop_first < n) ? reg_loop_first : n;
                if (reg_loop_repeats != 0 && nxt == loop_end &&
                    (int'(pass_count) < reg_loop_repeats || reg_loop_repeats < 0)) begin
                    nxt = loop_start;
                    if (pass_count != '1) pass_count = pass_count + 1'b1;
                end
                // also catches a frame left beyond a shrunken count
                if (nxt >= n) begin
                    nxt = 0;
                    pass_count = 16'd1;
                end
                cur_frame = FRAME_W'(nxt);
            end
            MODE_PREV: begin
                cur_frame = (cur_frame == 0) ? FRAME_W'(n - 1) : cur_frame - 1'b1;
            end
            MODE_SET: begin
                mag = (idx < 0) ? -idx : idx;
                if (mag < n) cur_frame = FRAME_W'((idx >= 0) ? mag : n - mag);
            end
            default: ; // unused mode keeps the frame
        endcase
        size_bytes = 64'(reg_row_stride) * 64'(reg_image_height);
        if (reg_alpha_plane) size_bytes += 64'(reg_image_width) * 64'(reg_image_height);
        rpt.frame  = cur_frame;
        rpt.offset = OFFSET_W'(size_bytes * 64'(cur_frame));
        pending_reports.insert(pending_reports.size(), rpt);
    endtask

    // entered and left at a falling edge; valid stays high into the next beat
    task automatic send_command(input logic [MODE_W-1:0] op, input logic [INDEX_W-1:0] target);
        while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
            cmd_valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_valid <= 1'b1;
        cmd_mode  <= op;
        cmd_index <= target;
        do @(posedge i_clk); while (!o_in_ready);
        predict_step(op, target);
        commands_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        cmd_valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_FRAMES_TOTAL: reg_frames_total = data[COUNT_W-1:0];
            REG_LOOP_FIRST: begin
                reg_loop_first = data[COUNT_W-1:0];
                pass_count = 16'd1;
            end
            REG_LOOP_LAST: begin
                reg_loop_last = data[COUNT_W-1:0];
                pass_count = 16'd1;
            end
            REG_LOOP_REPEATS: begin
                reg_loop_repeats = $signed(data[REPEAT_W-1:0]);
                pass_count = 16'd1;
            end
            REG_ROW_STRIDE:   reg_row_stride   = data[STRIDE_W-1:0];
            REG_IMAGE_WIDTH:  reg_image_width  = data[DIM_W-1:0];
            REG_IMAGE_HEIGHT: reg_image_height = data[DIM_W-1:0];
            REG_ALPHA_PLANE:  reg_alpha_plane  = data[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_settings(input logic [15:0] frames, input logic [15:0] first,
                                 input logic [15:0] last, input logic [15:0] repeats,
                                 input logic [15:0] stride, input logic [15:0] width,
                                 input logic [15:0] height, input logic [15:0] alpha);
        settle();
        write_reg(REG_FRAMES_TOTAL, frames);
        write_reg(REG_LOOP_FIRST, first);
        write_reg(REG_LOOP_LAST, last);
        write_reg(REG_LOOP_REPEATS, repeats);
        write_reg(REG_ROW_STRIDE, stride);
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_IMAGE_HEIGHT, height);
        write_reg(REG_ALPHA_PLANE, alpha);
        settings_loaded++;
    endtask

    task automatic load_random_settings();
        logic [15:0] frames;
        logic [15:0] first;
        logic [15:0] last;
        logic [15:0] repeats;
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 70) frames = 16'($urandom_range(2, 40));
        else if (pick < 90) frames = 16'($urandom_range(1, MAX_FRAMES));
        else frames = 16'($urandom);
        n = frames[COUNT_W-1:0];
        if (n == 0) n = 1;
        if (n > MAX_FRAMES) n = MAX_FRAMES;
        // mostly loop bounds inside the animation so that jumps really happen
        first = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, n - 1)) : 16'($urandom);
        last  = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(1, n)) : 16'($urandom);
        case ($urandom_range(0, 9))
            0:       repeats = 16'd0;
            1, 2, 3: repeats = 16'($urandom_range(1, 6));
            4, 5:    repeats = 16'hFFFF;
            6:       repeats = 16'(-$urandom_range(2, 100));
            7:       repeats = 16'h8000;
            8:       repeats = 16'h7FFF;
            default: repeats = 16'($urandom);
        endcase
        load_settings(frames, first, last, repeats,
                      ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 64)) : 16'($urandom),
                      ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 64)) : 16'($urandom),
                      ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 64)) : 16'($urandom),
                      16'($urandom));
    endtask

    task automatic send_random_command();
        logic [MODE_W-1:0] op;
        logic [INDEX_W-1:0] target;
        int unsigned pick;
        int unsigned n;
        n = active_frames();
        pick = $urandom_range(0, 99);
        target = INDEX_W'($urandom);
        if (pick < 55) op = MODE_NEXT;
        else if (pick < 70) op = MODE_PREV;
        else if (pick < 90) op = MODE_SET;
        else op = MODE_UNUSED;
        // most set commands aim inside the animation, from either end
        if (op == MODE_SET && $urandom_range(0, 99) < 75)
            target = INDEX_W'(int'($urandom_range(0, 2 * n - 2)) - int'(n - 1));
        send_command(op, target);
    endtask

    task automatic test_after_reset();
        send_command(MODE_NEXT, 12'd0);
        send_command(MODE_PREV, 12'd0);
        send_command(MODE_SET, 12'hFFF);
        send_command(MODE_UNUSED, 12'hFFF);
    endtask

    task automatic test_loop_rules();
        load_settings(16'd6, 16'd1, 16'd3, 16'd2, 16'd5, 16'd3, 16'd2, 16'd1);
        send_command(MODE_SET, 12'd0);
        // two passes through frames 1 and 2, then on to the wrap back to frame 0
        repeat (8) send_command(MODE_NEXT, 12'd0);
        settle();
        // loop start clamped to the count: the jump wraps to frame 0
        write_reg(REG_LOOP_FIRST, 16'd2047);
        write_reg(REG_LOOP_REPEATS, 16'hFFFF);
        send_command(MODE_SET, 12'd2);
        send_command(MODE_NEXT, 12'd0);
    endtask

    task automatic test_field_extremes();
        // oversized count clamps to the maximum, largest frame size overflows the offset
        load_settings(16'd2047, 16'd0, 16'd0, 16'd0, 16'h3FFF, 16'hFFF, 16'hFFF, 16'd1);
        send_command(MODE_SET, 12'h7FF);
        send_command(MODE_SET, 12'h800);
        send_command(MODE_SET, 12'd1023);
        send_command(MODE_NEXT, 12'd0);
        send_command(MODE_PREV, 12'd0);
        send_command(MODE_SET, 12'hC00);
        send_command(MODE_SET, 12'd1024);
        send_command(MODE_SET, 12'd700);
        settle();
        // zero count acts as one frame, current frame now beyond it
        write_reg(REG_FRAMES_TOTAL, 16'd0);
        send_command(MODE_PREV, 12'd0);
        send_command(MODE_NEXT, 12'd0);
        send_command(MODE_SET, 12'hFFF);
    endtask

    task automatic test_extreme_settings();
        load_settings(16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd0);
        repeat (60) send_random_command();
        load_settings(16'd1024, 16'd1024, 16'd1024, 16'd32767,
                      16'd8192, 16'd2048, 16'd2048, 16'd1);
        repeat (60) send_random_command();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 8; phase++) begin
            calm = (phase == 2);
            load_random_settings();
            for (int i = 0; i < 125; i++) begin
                if (phase == 5 && i == 60) settle();
                send_random_command();
            end
        end
        calm = 1'b0;
    endtask

    always @(posedge i_clk) begin : check_report
        t_frame_report want;
        if (i_rst_n && o_out_valid && out_ready) begin
            reports_seen++;
            if (pending_reports.size() == 0) begin
                $error("unexpected beat: frame_now %0d frame_offset %0d",
                       o_frame_now, o_frame_offset);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                if (o_frame_now !== want.frame) begin
                    $error("frame_now: expected %0d, actual %0d", want.frame, o_frame_now);
                    errors++;
                end
                if (o_frame_offset !== want.offset) begin
                    $error("frame_offset: expected %0d, actual %0d",
                           want.offset, o_frame_offset);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_valid && o_in_ready) || (o_out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $error("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_after_reset();
        test_loop_rules();
        test_field_extremes();
        test_extreme_settings();
        test_random_settings();
        settle();
        repeat (20) @(negedge i_clk);
        if (pending_reports.size() != 0) begin
            $error("%0d reports never arrived", pending_reports.size());
            errors++;
        end
        $display("summary: %0d commands sent and %0d reports checked", commands_sent,
                 reports_seen);
        $display("summary: %0d register settings, loops, wraps and set extremes", settings_loaded);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
